FILE: design/sgag_pkg.sv
// Shared constants, codes and types of the strided gather address generator.
package sgag_pkg;

    localparam int IDX_W            = 48;
    localparam int SIZE_W           = 32;
    localparam int PROD_W           = 2 * SIZE_W;
    localparam int CMD_W            = 1;
    localparam int SLOT_W           = 3;
    localparam int DIM_COUNT_W      = 4;
    localparam int MAX_DIMS_DEFAULT = 8;

    // Divider retires two quotient bits per cycle.
    localparam int DIV_STEPS        = IDX_W / 2;
    localparam int DIV_CNT_W        = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W        = 1;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET = 1'b1;

    localparam logic [CMD_W-1:0] CMD_LOAD      = 1'b0;
    localparam logic [CMD_W-1:0] CMD_TRANSLATE = 1'b1;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [SIZE_W-1:0] stride;
    } entry_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: design/sgag_if.sv
// Request and result channel interfaces of the strided gather address generator.
interface sgag_req_if;
    logic                          valid;
    logic                          ready;
    logic [sgag_pkg::CMD_W-1:0]    command;
    logic [sgag_pkg::SLOT_W-1:0]   dim_index;
    logic [sgag_pkg::SIZE_W-1:0]   dim_size;
    logic [sgag_pkg::SIZE_W-1:0]   source_stride;
    logic [sgag_pkg::IDX_W-1:0]    linear_index;

    modport source (
        output valid, command, dim_index, dim_size, source_stride, linear_index,
        input  ready
    );
    modport sink (
        input  valid, command, dim_index, dim_size, source_stride, linear_index,
        output ready
    );
endinterface

interface sgag_res_if;
    logic                          valid;
    logic                          ready;
    logic [sgag_pkg::IDX_W-1:0]    dest_index;
    logic [sgag_pkg::IDX_W-1:0]    source_offset;
    logic                          in_range;
    logic                          overflow;

    modport source (
        output valid, dest_index, source_offset, in_range, overflow,
        input  ready
    );
    modport sink (
        input  valid, dest_index, source_offset, in_range, overflow,
        output ready
    );
endinterface

FILE: design/sgag_tbl.sv
// Dimension table: one synchronous memory of extent and stride per slot.
module sgag_tbl #(
    parameter int MAX_DIMS = sgag_pkg::MAX_DIMS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1)-1:0] waddr,
    input  sgag_pkg::entry_t      wdata,
    input  logic [((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1)-1:0] raddr,
    output sgag_pkg::entry_t      rdata
);

    sgag_pkg::entry_t mem [MAX_DIMS];
    sgag_pkg::entry_t rdata_reg;

    // Write and registered read; no reset, entries are undefined until loaded.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/sgag_div.sv
// Iterative 48-by-32 restoring divider, two quotient bits per cycle.
module sgag_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sgag_pkg::IDX_W-1:0]    dividend,
    input  logic [sgag_pkg::SIZE_W-1:0]   divisor,
    output sgag_pkg::div_stat_t           stat,
    output logic [sgag_pkg::IDX_W-1:0]    quotient,
    output logic [sgag_pkg::SIZE_W-1:0]   remainder
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [sgag_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [sgag_pkg::IDX_W-1:0]       q_reg;
    logic [sgag_pkg::IDX_W-1:0]       q_next;
    logic [sgag_pkg::SIZE_W-1:0]      r_reg;
    logic [sgag_pkg::SIZE_W-1:0]      r_next;
    logic [sgag_pkg::SIZE_W-1:0]      d_reg;
    logic [sgag_pkg::SIZE_W:0]        trial;

    // Two shift-compare-subtract steps; the partial remainder stays below the divisor.
    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        trial  = '0;
        for (int k = 0; k < 2; k++)
        begin
            trial  = {r_next, q_next[sgag_pkg::IDX_W-1]};
            q_next = {q_next[sgag_pkg::IDX_W-2:0], 1'b0};
            if (trial >= {1'b0, d_reg})
            begin
                trial     = trial - {1'b0, d_reg};
                q_next[0] = 1'b1;
            end
            r_next = trial[sgag_pkg::SIZE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= sgag_pkg::DIV_CNT_W'(sgag_pkg::DIV_STEPS - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

FILE: design/strided_gather_address_gen_top.sv
// A load request writes the table on acceptance; a translate request walks the active
//   dimensions through the read, check, divide and accumulate states, then finishes.
// One request at a time: the next request is taken only once the walk is back in idle.
// A finished result waits in the output register while the next request is taken.
// Reset clears the configuration registers, the sequencer and the output register.
// The dimension table is not cleared; its entries are undefined until loaded.
module strided_gather_address_gen_top #(
    parameter int MAX_DIMS = sgag_pkg::MAX_DIMS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    sgag_req_if.sink                         request,
    sgag_res_if.source                       result,
    input  logic                             wr_en,
    input  logic [sgag_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [sgag_pkg::IDX_W-1:0]       wr_data
);

    // Table address, dimension counter and load-slot widths follow from the depth.
    localparam int AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CW = $clog2(MAX_DIMS + 1);
    localparam int SW = (AW > sgag_pkg::SLOT_W) ? AW : sgag_pkg::SLOT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_DIV,
        ST_ACC,
        ST_FIN
    } state_t;

    // Configuration registers.
    logic [sgag_pkg::DIM_COUNT_W-1:0] dim_count_reg;
    logic [sgag_pkg::IDX_W-1:0]       base_offset_reg;

    // Sequencer state and datapath registers.
    state_t                         state_reg,     state_next;
    logic [CW-1:0]                  dim_left_reg,  dim_left_next;
    logic [sgag_pkg::IDX_W-1:0]     rem_reg,       rem_next;
    logic [sgag_pkg::IDX_W-1:0]     sum_reg,       sum_next;
    logic                           ovf_reg,       ovf_next;
    logic                           zero_reg,      zero_next;
    logic [sgag_pkg::IDX_W-1:0]     lin_reg,       lin_next;
    logic [sgag_pkg::SIZE_W-1:0]    stride_reg,    stride_next;
    logic [sgag_pkg::PROD_W-1:0]    prod_reg,      prod_next;
    logic                           res_valid_reg, res_valid_next;
    logic [sgag_pkg::IDX_W-1:0]     res_dest_reg,  res_dest_next;
    logic [sgag_pkg::IDX_W-1:0]     res_src_reg,   res_src_next;
    logic                           res_range_reg, res_range_next;
    logic                           res_ovf_reg,   res_ovf_next;

    logic                           req_accept;
    logic                           load_we;
    logic [SW-1:0]                  slot_wide;
    logic [CW-1:0]                  n_active;
    logic [CW-1:0]                  dim_last;
    sgag_pkg::entry_t               load_entry;
    sgag_pkg::entry_t               rd_entry;
    logic                           div_start;
    sgag_pkg::div_stat_t            div_stat;
    logic [sgag_pkg::IDX_W-1:0]     div_quot;
    logic [sgag_pkg::SIZE_W-1:0]    div_rem;
    logic [sgag_pkg::PROD_W-1:0]    prod_w;
    logic [sgag_pkg::IDX_W:0]       acc_w;
    logic                           fin_range;

    // The user must issue configuration writes only while the block is idle; the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_count_reg   <= '0;
            base_offset_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                sgag_pkg::REG_DIM_COUNT:
                begin
                    dim_count_reg <= wr_data[sgag_pkg::DIM_COUNT_W-1:0];
                end
                sgag_pkg::REG_BASE_OFFSET:
                begin
                    base_offset_reg <= wr_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign request.ready = (state_reg == ST_IDLE);
    assign req_accept    = request.valid && request.ready;

    // Load requests write the table directly; drop slots beyond the table.
    assign slot_wide         = SW'(request.dim_index);
    assign load_we           = req_accept && (request.command == sgag_pkg::CMD_LOAD)
                               && (32'(request.dim_index) < MAX_DIMS);
    assign load_entry.size   = request.dim_size;
    assign load_entry.stride = request.source_stride;

    // A dimension count above the table depth acts as the full depth.
    assign n_active = (32'(dim_count_reg) >= MAX_DIMS) ? CW'(MAX_DIMS) : CW'(dim_count_reg);

    // Walk from the innermost active dimension outward.
    assign dim_last = dim_left_reg - CW'(1);

    sgag_tbl #(
        .MAX_DIMS (MAX_DIMS)
    ) u_tbl (
        .clk   (clk),
        .we    (load_we),
        .waddr (slot_wide[AW-1:0]),
        .wdata (load_entry),
        .raddr (dim_last[AW-1:0]),
        .rdata (rd_entry)
    );

    // Coordinate is the remainder by the extent; the quotient carries outward.
    sgag_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rem_reg),
        .divisor   (rd_entry.size),
        .stat      (div_stat),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Coordinate times source stride, registered before accumulation.
    assign prod_w = div_rem * stride_reg;

    // 49-bit sum catches a wrap past 48 bits.
    assign acc_w = {1'b0, sum_reg} + {1'b0, prod_reg[sgag_pkg::IDX_W-1:0]};

    // The index is in range exactly when no extent is zero and the
    // mixed-radix walk leaves nothing over.
    assign fin_range = !zero_reg && (rem_reg == '0);

    always_comb
    begin
        state_next     = state_reg;
        dim_left_next  = dim_left_reg;
        rem_next       = rem_reg;
        sum_next       = sum_reg;
        ovf_next       = ovf_reg;
        zero_next      = zero_reg;
        lin_next       = lin_reg;
        stride_next    = stride_reg;
        prod_next      = prod_reg;
        res_valid_next = res_valid_reg && !result.ready;
        res_dest_next  = res_dest_reg;
        res_src_next   = res_src_reg;
        res_range_next = res_range_reg;
        res_ovf_next   = res_ovf_reg;
        div_start      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept && (request.command == sgag_pkg::CMD_TRANSLATE))
                begin
                    lin_next      = request.linear_index;
                    rem_next      = request.linear_index;
                    sum_next      = base_offset_reg;
                    ovf_next      = 1'b0;
                    zero_next     = 1'b0;
                    dim_left_next = n_active;
                    state_next    = (n_active == '0) ? ST_FIN : ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                // A zero extent makes every index invalid; stop the walk.
                if (rd_entry.size == '0)
                begin
                    zero_next  = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    div_start   = 1'b1;
                    stride_next = rd_entry.stride;
                    state_next  = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    rem_next   = div_quot;
                    prod_next  = prod_w;
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                sum_next      = acc_w[sgag_pkg::IDX_W-1:0];
                ovf_next      = ovf_reg || acc_w[sgag_pkg::IDX_W]
                                || (prod_reg[sgag_pkg::PROD_W-1:sgag_pkg::IDX_W] != '0);
                dim_left_next = dim_last;
                state_next    = (dim_last == '0) ? ST_FIN : ST_READ;
            end
            ST_FIN:
            begin
                // Hold the result until the output register is free.
                if (!res_valid_reg || result.ready)
                begin
                    res_valid_next = 1'b1;
                    res_dest_next  = lin_reg;
                    res_range_next = fin_range;
                    res_src_next   = fin_range ? sum_reg : '0;
                    res_ovf_next   = fin_range && ovf_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dim_left_reg  <= '0;
            rem_reg       <= '0;
            sum_reg       <= '0;
            ovf_reg       <= 1'b0;
            zero_reg      <= 1'b0;
            lin_reg       <= '0;
            stride_reg    <= '0;
            prod_reg      <= '0;
            res_valid_reg <= 1'b0;
            res_dest_reg  <= '0;
            res_src_reg   <= '0;
            res_range_reg <= 1'b0;
            res_ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dim_left_reg  <= dim_left_next;
            rem_reg       <= rem_next;
            sum_reg       <= sum_next;
            ovf_reg       <= ovf_next;
            zero_reg      <= zero_next;
            lin_reg       <= lin_next;
            stride_reg    <= stride_next;
            prod_reg      <= prod_next;
            res_valid_reg <= res_valid_next;
            res_dest_reg  <= res_dest_next;
            res_src_reg   <= res_src_next;
            res_range_reg <= res_range_next;
            res_ovf_reg   <= res_ovf_next;
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.dest_index    = res_dest_reg;
    assign result.source_offset = res_src_reg;
    assign result.in_range      = res_range_reg;
    assign result.overflow      = res_ovf_reg;

`ifndef SYNTH
    a_translate_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        request.valid && request.ready && (request.command == sgag_pkg::CMD_TRANSLATE)
        |=> state_reg != ST_IDLE)
        else $error("translate request did not start the walk");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide step");

    a_walk_has_dims: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ || state_reg == ST_CHECK || state_reg == ST_DIV
         || state_reg == ST_ACC) |-> (dim_left_reg != '0 && 32'(dim_left_reg) <= MAX_DIMS))
        else $error("dimension counter out of range during walk");

    a_invalid_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.in_range
        |-> (result.source_offset == '0) && !result.overflow)
        else $error("invalid result carries an offset or overflow");
`endif

endmodule
